// ===== sv/biquad_filter_with_fir4_mode_assert.svh =====
// ----------------------------------------------------------------------------
// biquad filter assertion macros
// shared property templates for the filter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef BIQUAD_FILTER_WITH_FIR4_MODE_ASSERT_SVH
`define BIQUAD_FILTER_WITH_FIR4_MODE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BQF4_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bqf4 check failed");

// next-cycle implication, disabled during reset
`define BQF4_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bqf4 check failed");

`endif

// ===== sv/bqf4_pkg.sv =====
// ----------------------------------------------------------------------------
// bqf4_pkg
// register map, mode codes and tap cell control type
// ----------------------------------------------------------------------------
`default_nettype none

package bqf4_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_FILTER_MODE = 3'd0,
    REG_FF_COEF0    = 3'd1,
    REG_FF_COEF1    = 3'd2,
    REG_FF_COEF2    = 3'd3,
    REG_FF_COEF3    = 3'd4,
    REG_FB_COEF1    = 3'd5,
    REG_FB_COEF2    = 3'd6
  } reg_idx_e;

  localparam logic MODE_BIQUAD = 1'b0;
  localparam logic MODE_FIR4   = 1'b1;

  // load: take the tap input, fire: register coef * held tap
  typedef struct packed {
    logic load;
    logic fire;
  } tap_ctl_t;

endpackage

`default_nettype wire

// ===== sv/bqf4_stream_if.sv =====
// ----------------------------------------------------------------------------
// bqf4 stream interfaces
// valid/ready channels for input samples and filtered results
// ----------------------------------------------------------------------------
`default_nettype none

interface bqf4_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqf4_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

// ===== sv/bqf4_tap_cell.sv =====
// ----------------------------------------------------------------------------
// bqf4_tap_cell
// one delay-line tap: holds a sample and forms its weighted product
// ----------------------------------------------------------------------------
`default_nettype none

module bqf4_tap_cell #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  bqf4_pkg::tap_ctl_t                         ctl_i,
  input  wire  signed [SAMPLE_WIDTH-1:0]             tap_i,
  input  wire  signed [COEF_WIDTH-1:0]               coef_i,
  output logic signed [SAMPLE_WIDTH-1:0]             tap_o,
  output logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0]  prod_o
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0] tap_q;
  logic signed [PROD_W-1:0]       prod_d, prod_q;

  assign prod_d = tap_q * coef_i;

  // history starts from zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (ctl_i.load) begin
      tap_q <= tap_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fire) begin
      prod_q <= prod_d;
    end
  end

  assign tap_o  = tap_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== sv/biquad_filter_with_fir4_mode.sv =====
// ----------------------------------------------------------------------------
// biquad_filter_with_fir4_mode
// direct form 1 biquad with a four tap fir alternative, fixed point
// ----------------------------------------------------------------------------
//  port     dir  handshake             word
//  in_i     in   valid/ready           sample_in  (signed q1.23)
//  out_o    out  valid/ready           sample_out (signed q1.23), clipped
//  apb      in   psel/penable/pwrite   7 registers at byte offset 4*index
//
//  a taken word issues at the next edge at the earliest: products are
//  registered in the tap cells at issue, then the sum in the sum register,
//  then the rounded, saturated word in the output register
//  y1/y2 feedback runs through the product and sum stages: a word issues once
//  both have drained; a new word is taken while earlier ones are in flight
//  rst_ni clears the history, coefficients and all valid flags
//  a stalled output holds its word; one more word can reach the sum stage
//  and one more wait in the input register, then in_i.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_filter_with_fir4_mode #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  bqf4_in_if.sink                               in_i,
  bqf4_out_if.source                            out_o,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [bqf4_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire  [bqf4_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [bqf4_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  import bqf4_pkg::*;

  localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W   = PROD_W + 3;          // five products, no overflow
  localparam int FRAC_SH = COEF_WIDTH - 4;      // product frac bits beyond sample
  localparam int SH_W    = ACC_W - FRAC_SH;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_SH - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                         mode_q;
  logic signed [COEF_WIDTH-1:0] ff_coef_q [4];
  logic signed [COEF_WIDTH-1:0] fb_coef_q [2];
  logic                         cfg_wr;
  reg_idx_e                     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_BIQUAD;
      ff_coef_q <= '{default: '0};
      fb_coef_q <= '{default: '0};
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FILTER_MODE: mode_q       <= pwdata[0];
        REG_FF_COEF0:    ff_coef_q[0] <= pwdata[COEF_WIDTH-1:0];
        REG_FF_COEF1:    ff_coef_q[1] <= pwdata[COEF_WIDTH-1:0];
        REG_FF_COEF2:    ff_coef_q[2] <= pwdata[COEF_WIDTH-1:0];
        REG_FF_COEF3:    ff_coef_q[3] <= pwdata[COEF_WIDTH-1:0];
        REG_FB_COEF1:    fb_coef_q[0] <= pwdata[COEF_WIDTH-1:0];
        REG_FB_COEF2:    fb_coef_q[1] <= pwdata[COEF_WIDTH-1:0];
        default:         ; // unmapped offset, write dropped
      endcase
    end
  end

  // coefficients read back sign extended
  always_comb begin
    unique case (cfg_idx)
      REG_FILTER_MODE: prdata = APB_DATA_W'(mode_q);
      REG_FF_COEF0:    prdata = APB_DATA_W'(ff_coef_q[0]);
      REG_FF_COEF1:    prdata = APB_DATA_W'(ff_coef_q[1]);
      REG_FF_COEF2:    prdata = APB_DATA_W'(ff_coef_q[2]);
      REG_FF_COEF3:    prdata = APB_DATA_W'(ff_coef_q[3]);
      REG_FB_COEF1:    prdata = APB_DATA_W'(fb_coef_q[0]);
      REG_FB_COEF2:    prdata = APB_DATA_W'(fb_coef_q[1]);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // x0 cell doubles as the input register; p = products, s = sum, o = output
  // --------------------------------------------------------------------------
  logic x0_vld_q, p_vld_q, s_vld_q, o_vld_q;
  logic in_acc, issue, p_adv, s_adv, o_free, y_load;

  assign o_free = !o_vld_q || out_o.ready;
  assign s_adv  = s_vld_q && o_free;
  assign p_adv  = p_vld_q && (!s_vld_q || s_adv);
  // the next word needs y1 from the previous one, so wait for p and s to drain
  assign issue  = x0_vld_q && !p_vld_q && !s_vld_q;
  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = !x0_vld_q || issue;
  // output history moves only in biquad mode
  assign y_load = s_adv && (mode_q == MODE_BIQUAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_vld_q <= 1'b0;
      p_vld_q  <= 1'b0;
      s_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        x0_vld_q <= 1'b1;
      end else if (issue) begin
        x0_vld_q <= 1'b0;
      end
      if (issue) begin
        p_vld_q <= 1'b1;
      end else if (p_adv) begin
        p_vld_q <= 1'b0;
      end
      if (p_adv) begin
        s_vld_q <= 1'b1;
      end else if (s_adv) begin
        s_vld_q <= 1'b0;
      end
      if (s_adv) begin
        o_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tap cell chains: x, x1, x2, x3 feedforward and y1, y2 feedback
  // --------------------------------------------------------------------------
  tap_ctl_t x0_ctl, tap_ctl, y_ctl;

  assign x0_ctl  = '{load: in_acc, fire: issue};
  assign tap_ctl = '{load: issue,  fire: issue};
  assign y_ctl   = '{load: y_load, fire: issue};

  logic signed [SAMPLE_WIDTH-1:0] x_tap [4];
  logic signed [SAMPLE_WIDTH-1:0] y_tap [2];
  logic signed [PROD_W-1:0]       ff_prod [4];
  logic signed [PROD_W-1:0]       fb_prod [2];
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  bqf4_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_x0 (
    .clk_i, .rst_ni, .ctl_i(x0_ctl), .tap_i(in_i.sample_in), .coef_i(ff_coef_q[0]),
    .tap_o(x_tap[0]), .prod_o(ff_prod[0])
  );

  for (genvar k = 1; k < 4; k++) begin : g_ff
    bqf4_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_x (
      .clk_i, .rst_ni, .ctl_i(tap_ctl), .tap_i(x_tap[k-1]), .coef_i(ff_coef_q[k]),
      .tap_o(x_tap[k]), .prod_o(ff_prod[k])
    );
  end

  bqf4_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_y1 (
    .clk_i, .rst_ni, .ctl_i(y_ctl), .tap_i(y_sat), .coef_i(fb_coef_q[0]),
    .tap_o(y_tap[0]), .prod_o(fb_prod[0])
  );

  bqf4_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_y2 (
    .clk_i, .rst_ni, .ctl_i(y_ctl), .tap_i(y_tap[0]), .coef_i(fb_coef_q[1]),
    .tap_o(y_tap[1]), .prod_o(fb_prod[1])
  );

  // --------------------------------------------------------------------------
  // sum stage: fir4 adds the x3 tap, biquad subtracts the feedback taps
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] sum_d, sum_q, tail;

  always_comb begin
    if (mode_q == MODE_FIR4) begin
      tail = ACC_W'(ff_prod[3]);
    end else begin
      tail = -ACC_W'(fb_prod[0]) - ACC_W'(fb_prod[1]);
    end
    sum_d = ACC_W'(ff_prod[0]) + ACC_W'(ff_prod[1]) + ACC_W'(ff_prod[2]) + tail;
  end

  always_ff @(posedge clk_i) begin
    if (p_adv) begin
      sum_q <= sum_d;
    end
  end

  // --------------------------------------------------------------------------
  // round half up, drop fraction bits, saturate to sample range
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]        rnd;
  logic signed [SH_W-1:0]         shf;
  logic                           fits, clip_d;
  logic signed [SAMPLE_WIDTH-1:0] o_sample_q;
  logic                           o_clip_q;

  always_comb begin
    rnd    = sum_q + RND_HALF;
    shf    = rnd[ACC_W-1:FRAC_SH];
    fits   = (shf[SH_W-1:SAMPLE_WIDTH-1] == '0) || (shf[SH_W-1:SAMPLE_WIDTH-1] == '1);
    clip_d = !fits;
    if (fits) begin
      y_sat = shf[SAMPLE_WIDTH-1:0];
    end else if (shf[SH_W-1]) begin
      y_sat = SMP_MIN;
    end else begin
      y_sat = SMP_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_adv) begin
      o_sample_q <= y_sat;
      o_clip_q   <= clip_d;
    end
  end

  assign out_o.valid      = o_vld_q;
  assign out_o.sample_out = o_sample_q;
  assign out_o.clipped    = o_clip_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
`include "biquad_filter_with_fir4_mode_assert.svh"

  // feedback ordering: never more than one word between issue and output
  `BQF4_ASSERT_IMP(a_one_in_flight, clk_i, rst_ni, 1'b1, $countones({p_vld_q, s_vld_q}) <= 1)
  // y1 history tracks the word just written to the output register
  `BQF4_ASSERT_NXT(a_y1_tracks_out, clk_i, rst_ni, y_load, y_tap[0] == o_sample_q)
  // a clipped word sits at one of the range limits
  `BQF4_ASSERT_IMP(a_clip_at_limit, clk_i, rst_ni, o_vld_q && o_clip_q,
                   (o_sample_q == SMP_MAX) || (o_sample_q == SMP_MIN))

endmodule

`default_nettype wire
